>>> hw/rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Types, codes and command framing shared by the SD SPI block sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

	localparam int unsigned BLOCK_BYTES = 512;

	typedef logic [1:0] action_t;
	localparam action_t ACT_BYTE  = 2'd0;
	localparam action_t ACT_INIT  = 2'd1;
	localparam action_t ACT_READ  = 2'd2;
	localparam action_t ACT_WRITE = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOT_IDLE = 2'd1;
	localparam status_t ST_CMD_REJ  = 2'd2;
	localparam status_t ST_DATA_REJ = 2'd3;

	localparam logic [7:0] CMD_PREFIX  = 8'h40;
	localparam logic [5:0] CMD_GO_IDLE = 6'h00;
	localparam logic [5:0] CMD_SEND_OP = 6'h01;
	localparam logic [5:0] CMD_RD_BLK  = 6'h11;
	localparam logic [5:0] CMD_WR_BLK  = 6'h18;
	localparam logic [7:0] CRC_CMD0    = 8'h95;
	localparam logic [31:0] ARG_CMD1   = 32'h00ff_c000;
	localparam logic [7:0] BYTE_IDLE   = 8'hff;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] TOKEN_START = 8'hfe;
	localparam logic [7:0] R1_READY    = 8'h00;
	localparam logic [7:0] R1_IDLE     = 8'h01;
	localparam logic [3:0] DRESP_MASKOK = 4'h5;

	typedef struct packed {
		logic [7:0] send_byte;
		logic       select_active;
		logic       exchange_request;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       take_write_byte;
		logic       done_res;
		status_t    status;
	} result_t;

	function automatic logic [7:0] cmd_byte(
		input logic [5:0]  code,
		input logic [31:0] arg,
		input logic [7:0]  crc,
		input logic [2:0]  k
	);
		logic [7:0] b;
		unique case (k)
			3'd0: b = CMD_PREFIX | {2'b00, code};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: b = crc;
		endcase
		return b;
	endfunction

endpackage

>>> hw/rtl/sd_spi_block_sequencer_core.sv
// SD card SPI-mode host sequencer at byte level. One item per clock cycle is
// accepted unless in_stall is high; each item yields exactly one result, via
// an input register and a result register, and the next-byte decision is one
// pass of logic between them. A start item selects init, block read or block
// write; each result names the next byte to shift out and the select level,
// and the next byte item returns the card's answer. transfer_length may only
// be written while no item is in flight.
// ----------------------------------------------------------------------------
// sd_spi_block_sequencer_core
// Init, single-block read and single-block write sequencing for SPI mode.
// ----------------------------------------------------------------------------
module sd_spi_block_sequencer_core #(
	parameter int unsigned POLL_LIMIT = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [9:0]              transfer_length,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic [31:0]             block_address,
	input  logic [7:0]              card_byte,
	input  logic [7:0]              write_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              send_byte,
	output logic                    select_active,
	output logic                    exchange_request,
	output logic                    data_valid,
	output logic [7:0]              data_byte,
	output logic                    take_write_byte,
	output logic                    done_res,
	output logic [1:0]              status
);

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_WAKE   = 4'd1;
	localparam logic [3:0] PH_CMD0   = 4'd2;
	localparam logic [3:0] PH_RESP0  = 4'd3;
	localparam logic [3:0] PH_GAP    = 4'd4;
	localparam logic [3:0] PH_CMD1   = 4'd5;
	localparam logic [3:0] PH_RESP1  = 4'd6;
	localparam logic [3:0] PH_CMDRW  = 4'd7;
	localparam logic [3:0] PH_RESPRW = 4'd8;
	localparam logic [3:0] PH_TOKEN  = 4'd9;
	localparam logic [3:0] PH_RDATA  = 4'd10;
	localparam logic [3:0] PH_PAD    = 4'd11;
	localparam logic [3:0] PH_WDATA  = 4'd12;
	localparam logic [3:0] PH_WRESP  = 4'd13;
	localparam logic [3:0] PH_BUSY   = 4'd14;
	localparam logic [3:0] PH_TAIL   = 4'd15;

	localparam logic [9:0] BLK       = 10'(sdspi_pkg::BLOCK_BYTES);
	localparam logic [9:0] BLK_CRC   = 10'(sdspi_pkg::BLOCK_BYTES + 2);
	localparam logic [9:0] WAKE_LEN  = 10'd10;
	localparam logic [9:0] FRAME_LEN = 10'd6;
	localparam logic [9:0] PAD_LEN   = 10'd3;
	localparam logic [3:0] POLL_MAX  = 4'(POLL_LIMIT);

	logic [9:0]  len_q;
	logic        v_s1;
	logic [1:0]  action_s1;
	logic [31:0] addr_s1;
	logic [7:0]  cb_s1;
	logic [7:0]  wb_s1;

	logic [3:0]  phase_q, phase_n;
	logic [9:0]  bc_q, bc_n, bc_inc;
	logic [3:0]  pc_q, pc_n, pc_inc;
	logic [31:0] addr_q, addr_n;
	logic [1:0]  op_q, op_n;
	logic [7:0]  resp_q, resp_n;

	logic                 out_v_q;
	sdspi_pkg::result_t   res_q, res_n;

	logic        adv;
	logic        fire;
	logic [9:0]  eff_len;
	logic [9:0]  wd_cnt;
	logic        wd_use;
	logic [5:0]  cur_code;
	logic [31:0] cur_arg;
	logic [7:0]  cur_crc;
	logic        cb_wait;

	assign cfg_ready = 1'b1;
	assign adv       = !out_v_q || !out_stall;
	assign fire      = v_s1 && adv;
	assign in_stall  = v_s1 && !adv;
	assign eff_len   = (len_q > BLK) ? BLK : len_q;
	assign bc_inc    = bc_q + 10'd1;
	assign pc_inc    = pc_q + 4'd1;
	assign cb_wait   = (cb_s1 != sdspi_pkg::R1_READY) && (cb_s1 != sdspi_pkg::R1_IDLE);

	always_comb begin
		unique case (phase_q)
			PH_CMD0: begin
				cur_code = sdspi_pkg::CMD_GO_IDLE;
				cur_arg  = '0;
				cur_crc  = sdspi_pkg::CRC_CMD0;
			end
			PH_CMD1: begin
				cur_code = sdspi_pkg::CMD_SEND_OP;
				cur_arg  = sdspi_pkg::ARG_CMD1;
				cur_crc  = sdspi_pkg::BYTE_IDLE;
			end
			default: begin
				cur_code = (op_q == sdspi_pkg::ACT_WRITE) ? sdspi_pkg::CMD_WR_BLK
					: sdspi_pkg::CMD_RD_BLK;
				cur_arg  = addr_q;
				cur_crc  = sdspi_pkg::BYTE_IDLE;
			end
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		bc_n    = bc_q;
		pc_n    = pc_q;
		addr_n  = addr_q;
		op_n    = op_q;
		resp_n  = resp_q;
		wd_use  = 1'b0;
		wd_cnt  = bc_inc;
		res_n   = '0;
		res_n.send_byte = sdspi_pkg::BYTE_IDLE;

		if (action_s1 != sdspi_pkg::ACT_BYTE) begin
			op_n   = action_s1;
			addr_n = addr_s1;
			bc_n   = '0;
			pc_n   = '0;
			resp_n = '0;
			res_n.exchange_request = 1'b1;
			if (action_s1 == sdspi_pkg::ACT_INIT) begin
				phase_n = PH_WAKE;
			end else begin
				phase_n = PH_CMDRW;
				res_n.select_active = 1'b1;
				res_n.send_byte = sdspi_pkg::cmd_byte(
					(action_s1 == sdspi_pkg::ACT_WRITE) ? sdspi_pkg::CMD_WR_BLK
						: sdspi_pkg::CMD_RD_BLK,
					addr_s1, sdspi_pkg::BYTE_IDLE, 3'd0);
			end
		end else begin
			unique case (phase_q)
				PH_WAKE: begin
					res_n.exchange_request = 1'b1;
					if (bc_inc < WAKE_LEN) begin
						bc_n = bc_inc;
					end else begin
						phase_n = PH_CMD0;
						bc_n    = '0;
						res_n.select_active = 1'b1;
						res_n.send_byte = sdspi_pkg::cmd_byte(sdspi_pkg::CMD_GO_IDLE,
							'0, sdspi_pkg::CRC_CMD0, 3'd0);
					end
				end
				PH_CMD0, PH_CMD1, PH_CMDRW: begin
					bc_n = bc_inc;
					res_n.select_active    = 1'b1;
					res_n.exchange_request = 1'b1;
					if (bc_inc < FRAME_LEN) begin
						res_n.send_byte = sdspi_pkg::cmd_byte(cur_code, cur_arg, cur_crc,
							bc_inc[2:0]);
					end else begin
						phase_n = phase_q + 4'd1;
						pc_n    = '0;
					end
				end
				PH_RESP0, PH_RESP1, PH_RESPRW: begin
					pc_n = pc_inc;
					res_n.select_active    = 1'b1;
					res_n.exchange_request = 1'b1;
					if (cb_wait && (pc_inc < POLL_MAX)) begin
						phase_n = phase_q;
					end else if (phase_q == PH_RESP0) begin
						if (cb_s1 != sdspi_pkg::R1_IDLE) begin
							phase_n = PH_IDLE;
							res_n.select_active    = 1'b0;
							res_n.exchange_request = 1'b0;
							res_n.done_res = 1'b1;
							res_n.status   = sdspi_pkg::ST_NOT_IDLE;
						end else begin
							phase_n = PH_GAP;
							res_n.select_active = 1'b0;
						end
					end else if (phase_q == PH_RESP1) begin
						if (cb_s1 == sdspi_pkg::R1_IDLE) begin
							phase_n = PH_GAP;
							res_n.select_active = 1'b0;
						end else if (cb_s1 == sdspi_pkg::R1_READY) begin
							phase_n = PH_TAIL;
							res_n.select_active = 1'b0;
						end else begin
							phase_n = PH_IDLE;
							res_n.select_active    = 1'b0;
							res_n.exchange_request = 1'b0;
							res_n.done_res = 1'b1;
							res_n.status   = sdspi_pkg::ST_CMD_REJ;
						end
					end else if (cb_s1 != sdspi_pkg::R1_READY) begin
						phase_n = PH_IDLE;
						res_n.select_active    = 1'b0;
						res_n.exchange_request = 1'b0;
						res_n.done_res = 1'b1;
						res_n.status   = sdspi_pkg::ST_CMD_REJ;
					end else if (op_q == sdspi_pkg::ACT_WRITE) begin
						phase_n = PH_PAD;
						bc_n    = '0;
					end else begin
						phase_n = PH_TOKEN;
					end
				end
				PH_GAP: begin
					phase_n = PH_CMD1;
					bc_n    = '0;
					res_n.select_active    = 1'b1;
					res_n.exchange_request = 1'b1;
					res_n.send_byte = sdspi_pkg::cmd_byte(sdspi_pkg::CMD_SEND_OP,
						sdspi_pkg::ARG_CMD1, sdspi_pkg::BYTE_IDLE, 3'd0);
				end
				PH_TOKEN: begin
					if (cb_s1 == sdspi_pkg::TOKEN_START) begin
						phase_n = PH_RDATA;
						bc_n    = '0;
					end
					res_n.select_active    = 1'b1;
					res_n.exchange_request = 1'b1;
				end
				PH_RDATA: begin
					bc_n = bc_inc;
					res_n.exchange_request = 1'b1;
					if (bc_inc < BLK_CRC) begin
						res_n.select_active = 1'b1;
					end else begin
						phase_n = PH_TAIL;
					end
					if (bc_q < eff_len) begin
						res_n.data_valid = 1'b1;
						res_n.data_byte  = cb_s1;
					end
				end
				PH_PAD: begin
					bc_n = bc_inc;
					res_n.select_active    = 1'b1;
					res_n.exchange_request = 1'b1;
					if (bc_inc == PAD_LEN) begin
						res_n.send_byte = sdspi_pkg::TOKEN_START;
					end else if (bc_inc > PAD_LEN) begin
						phase_n = PH_WDATA;
						bc_n    = '0;
						wd_cnt  = '0;
						wd_use  = 1'b1;
					end
				end
				PH_WDATA: begin
					bc_n = bc_inc;
					res_n.select_active    = 1'b1;
					res_n.exchange_request = 1'b1;
					if (bc_inc < BLK_CRC) begin
						wd_use = 1'b1;
					end else begin
						phase_n = PH_WRESP;
					end
				end
				PH_WRESP: begin
					resp_n  = cb_s1;
					phase_n = PH_BUSY;
					res_n.select_active    = 1'b1;
					res_n.exchange_request = 1'b1;
				end
				PH_BUSY: begin
					res_n.exchange_request = 1'b1;
					if (cb_s1 == sdspi_pkg::BYTE_ZERO) begin
						res_n.select_active = 1'b1;
					end else begin
						phase_n = PH_TAIL;
					end
				end
				PH_TAIL: begin
					phase_n = PH_IDLE;
					res_n.done_res = 1'b1;
					if ((op_q == sdspi_pkg::ACT_WRITE) && (resp_q[3:0] != sdspi_pkg::DRESP_MASKOK)) begin
						res_n.status = sdspi_pkg::ST_DATA_REJ;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
			if (wd_use) begin
				if (wd_cnt < eff_len) begin
					res_n.send_byte       = wb_s1;
					res_n.take_write_byte = 1'b1;
				end else if (wd_cnt < BLK) begin
					res_n.send_byte = sdspi_pkg::BYTE_ZERO;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= BLK;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
			phase_q <= PH_IDLE;
			bc_q    <= '0;
			pc_q    <= '0;
			addr_q  <= '0;
			op_q    <= '0;
			resp_q  <= '0;
		end else begin
			if (cfg_valid) begin
				len_q <= transfer_length;
			end
			if (!in_stall) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				out_v_q <= v_s1;
			end
			if (fire) begin
				phase_q <= phase_n;
				bc_q    <= bc_n;
				pc_q    <= pc_n;
				addr_q  <= addr_n;
				op_q    <= op_n;
				resp_q  <= resp_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			addr_s1   <= block_address;
			cb_s1     <= card_byte;
			wb_s1     <= write_byte;
		end
		if (fire) begin
			res_q <= res_n;
		end
	end

	assign out_valid        = out_v_q;
	assign send_byte        = res_q.send_byte;
	assign select_active    = res_q.select_active;
	assign exchange_request = res_q.exchange_request;
	assign data_valid       = res_q.data_valid;
	assign data_byte        = res_q.data_byte;
	assign take_write_byte  = res_q.take_write_byte;
	assign done_res         = res_q.done_res;
	assign status           = res_q.status;

endmodule

>>> hw/rtl/sdspi_checker.sv
// ----------------------------------------------------------------------------
// sdspi_checker
// Port-level checks on the result channel of the SD SPI block sequencer.
// ----------------------------------------------------------------------------
module sdspi_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] send_byte,
	input logic       select_active,
	input logic       exchange_request,
	input logic       data_valid,
	input logic [7:0] data_byte,
	input logic       take_write_byte,
	input logic       done_res,
	input logic [1:0] status
);

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !select_active && !exchange_request
			&& send_byte == sdspi_pkg::BYTE_IDLE)
		else $error("done item keeps select or requests an exchange");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != sdspi_pkg::ST_OK |-> done_res)
		else $error("nonzero status without done");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_byte == 8'h00)
		else $error("data byte set without data valid");

	a_take_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && take_write_byte |-> select_active && exchange_request && !data_valid)
		else $error("write byte taken outside a selected exchange");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(send_byte) && $stable(done_res))
		else $error("stalled item changed");

endmodule

bind sd_spi_block_sequencer_core sdspi_checker u_sdspi_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.send_byte        (send_byte),
	.select_active    (select_active),
	.exchange_request (exchange_request),
	.data_valid       (data_valid),
	.data_byte        (data_byte),
	.take_write_byte  (take_write_byte),
	.done_res         (done_res),
	.status           (status)
);

>>> dv/sd_spi_block_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_block_sequencer_core_tb
// Runs init, block read and block write exchanges against generated card
// answers under several transfer lengths and flow-control patterns. Each
// result is predicted in the bench and compared field by field.
// ----------------------------------------------------------------------------
module sd_spi_block_sequencer_core_tb;

	localparam int unsigned POLL_LIMIT      = 9;
	localparam int unsigned WATCHDOG_CYCLES = 2000;
	localparam int unsigned DRAIN_CYCLES    = 4;
	localparam int unsigned HOLD_CYCLES     = 150;
	localparam int unsigned MAX_REPORTS     = 10;

	typedef enum logic [4:0] {
		PH_IDLE, PH_WAKE, PH_CMD0, PH_RESP0, PH_GAP, PH_CMD1, PH_RESP1, PH_CMDRW,
		PH_RESPRW, PH_TOKEN, PH_RDATA, PH_PAD, PH_WDATA, PH_WRESP, PH_BUSY, PH_TAIL
	} seq_phase_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [9:0]         transfer_length = 10'd512;
	logic               in_valid = 1'b0;
	logic               in_stall;
	sdspi_pkg::action_t action = sdspi_pkg::ACT_BYTE;
	logic [31:0]        block_address = '0;
	logic [7:0]         card_byte = '0;
	logic [7:0]         write_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         send_byte;
	logic               select_active;
	logic               exchange_request;
	logic               data_valid;
	logic [7:0]         data_byte;
	logic               take_write_byte;
	logic               done_res;
	sdspi_pkg::status_t status;

	seq_phase_t         seq_phase = PH_IDLE;
	logic [9:0]         seq_count = '0;
	logic [3:0]         seq_polls = '0;
	logic [31:0]        seq_addr = '0;
	sdspi_pkg::action_t seq_op = sdspi_pkg::ACT_BYTE;
	logic [7:0]         seq_resp = '0;
	logic [9:0]         seq_len = 10'd512;

	sdspi_pkg::result_t pending_results[$];
	int unsigned        mismatches = 0;
	int unsigned        items_done = 0;
	int unsigned        send_idle_pct = 0;
	int unsigned        recv_pct = 0;
	int unsigned        hold_ticket = 0;
	bit                 card_mute = 1'b0;

	sd_spi_block_sequencer_core #(
		.POLL_LIMIT(POLL_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.transfer_length(transfer_length),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.block_address(block_address),
		.card_byte(card_byte),
		.write_byte(write_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.send_byte(send_byte),
		.select_active(select_active),
		.exchange_request(exchange_request),
		.data_valid(data_valid),
		.data_byte(data_byte),
		.take_write_byte(take_write_byte),
		.done_res(done_res),
		.status(status)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic bit chance(input int unsigned pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic sdspi_pkg::result_t bus_byte(input logic [7:0] b, input logic sel,
			input logic req);
		sdspi_pkg::result_t r;
		r = '0;
		r.send_byte = b;
		r.select_active = sel;
		r.exchange_request = req;
		return r;
	endfunction

	function automatic sdspi_pkg::result_t card_done(input sdspi_pkg::status_t st);
		sdspi_pkg::result_t r;
		r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b0);
		r.done_res = 1'b1;
		r.status = st;
		seq_phase = PH_IDLE;
		return r;
	endfunction

	function automatic logic [7:0] frame_byte(input logic [9:0] k);
		logic [5:0]  code;
		logic [31:0] arg;
		logic [7:0]  crc;
		crc = sdspi_pkg::BYTE_IDLE;
		arg = seq_addr;
		code = (seq_op == sdspi_pkg::ACT_WRITE) ? sdspi_pkg::CMD_WR_BLK
			: sdspi_pkg::CMD_RD_BLK;
		if (seq_phase == PH_CMD0) begin
			code = sdspi_pkg::CMD_GO_IDLE;
			arg = '0;
			crc = sdspi_pkg::CRC_CMD0;
		end else if (seq_phase == PH_CMD1) begin
			code = sdspi_pkg::CMD_SEND_OP;
			arg = sdspi_pkg::ARG_CMD1;
		end
		case (k)
			10'd0: return sdspi_pkg::CMD_PREFIX | {2'b00, code};
			10'd1: return arg[31:24];
			10'd2: return arg[23:16];
			10'd3: return arg[15:8];
			10'd4: return arg[7:0];
			default: return crc;
		endcase
	endfunction

	function automatic sdspi_pkg::result_t data_out_byte(input logic [7:0] wb,
			input int unsigned lim);
		sdspi_pkg::result_t r;
		if (seq_count < lim) begin
			r = bus_byte(wb, 1'b1, 1'b1);
			r.take_write_byte = 1'b1;
		end else if (seq_count < sdspi_pkg::BLOCK_BYTES) begin
			r = bus_byte(sdspi_pkg::BYTE_ZERO, 1'b1, 1'b1);
		end else begin
			r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
		end
		return r;
	endfunction

	function automatic sdspi_pkg::result_t next_exchange(input sdspi_pkg::action_t act,
			input logic [31:0] addr, input logic [7:0] cb, input logic [7:0] wb);
		sdspi_pkg::result_t r;
		int unsigned        lim;
		bit                 passing;
		lim = (seq_len > sdspi_pkg::BLOCK_BYTES) ? sdspi_pkg::BLOCK_BYTES : seq_len;
		r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b0);
		if (act != sdspi_pkg::ACT_BYTE) begin
			seq_op = act;
			seq_addr = addr;
			seq_count = '0;
			seq_polls = '0;
			seq_resp = '0;
			if (act == sdspi_pkg::ACT_INIT) begin
				seq_phase = PH_WAKE;
				r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b1);
			end else begin
				seq_phase = PH_CMDRW;
				r = bus_byte(frame_byte(10'd0), 1'b1, 1'b1);
			end
			return r;
		end
		case (seq_phase)
			PH_WAKE: begin
				seq_count = seq_count + 1'b1;
				if (seq_count < 10) begin
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b1);
				end else begin
					seq_phase = PH_CMD0;
					seq_count = '0;
					r = bus_byte(frame_byte(10'd0), 1'b1, 1'b1);
				end
			end
			PH_CMD0, PH_CMD1, PH_CMDRW: begin
				seq_count = seq_count + 1'b1;
				if (seq_count < 6) begin
					r = bus_byte(frame_byte(seq_count), 1'b1, 1'b1);
				end else begin
					case (seq_phase)
						PH_CMD0: seq_phase = PH_RESP0;
						PH_CMD1: seq_phase = PH_RESP1;
						default: seq_phase = PH_RESPRW;
					endcase
					seq_polls = '0;
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
				end
			end
			PH_RESP0, PH_RESP1, PH_RESPRW: begin
				seq_polls = seq_polls + 1'b1;
				if (cb != sdspi_pkg::R1_READY && cb != sdspi_pkg::R1_IDLE
						&& seq_polls < POLL_LIMIT) begin
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
				end else if (seq_phase == PH_RESP0) begin
					if (cb != sdspi_pkg::R1_IDLE) begin
						r = card_done(sdspi_pkg::ST_NOT_IDLE);
					end else begin
						seq_phase = PH_GAP;
						r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b1);
					end
				end else if (seq_phase == PH_RESP1) begin
					if (cb == sdspi_pkg::R1_IDLE) begin
						seq_phase = PH_GAP;
						r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b1);
					end else if (cb == sdspi_pkg::R1_READY) begin
						seq_phase = PH_TAIL;
						r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b1);
					end else begin
						r = card_done(sdspi_pkg::ST_CMD_REJ);
					end
				end else if (cb != sdspi_pkg::R1_READY) begin
					r = card_done(sdspi_pkg::ST_CMD_REJ);
				end else if (seq_op == sdspi_pkg::ACT_WRITE) begin
					seq_phase = PH_PAD;
					seq_count = '0;
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
				end else begin
					seq_phase = PH_TOKEN;
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
				end
			end
			PH_GAP: begin
				seq_phase = PH_CMD1;
				seq_count = '0;
				r = bus_byte(frame_byte(10'd0), 1'b1, 1'b1);
			end
			PH_TOKEN: begin
				if (cb == sdspi_pkg::TOKEN_START) begin
					seq_phase = PH_RDATA;
					seq_count = '0;
				end
				r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
			end
			PH_RDATA: begin
				passing = seq_count < lim;
				seq_count = seq_count + 1'b1;
				if (seq_count < sdspi_pkg::BLOCK_BYTES + 2) begin
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
				end else begin
					seq_phase = PH_TAIL;
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b1);
				end
				if (passing) begin
					r.data_valid = 1'b1;
					r.data_byte = cb;
				end
			end
			PH_PAD: begin
				seq_count = seq_count + 1'b1;
				if (seq_count < 3) begin
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
				end else if (seq_count == 3) begin
					r = bus_byte(sdspi_pkg::TOKEN_START, 1'b1, 1'b1);
				end else begin
					seq_phase = PH_WDATA;
					seq_count = '0;
					r = data_out_byte(wb, lim);
				end
			end
			PH_WDATA: begin
				seq_count = seq_count + 1'b1;
				if (seq_count < sdspi_pkg::BLOCK_BYTES + 2) begin
					r = data_out_byte(wb, lim);
				end else begin
					seq_phase = PH_WRESP;
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
				end
			end
			PH_WRESP: begin
				seq_resp = cb;
				seq_phase = PH_BUSY;
				r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
			end
			PH_BUSY: begin
				if (cb == sdspi_pkg::BYTE_ZERO) begin
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1);
				end else begin
					seq_phase = PH_TAIL;
					r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b1);
				end
			end
			PH_TAIL: begin
				if (seq_op == sdspi_pkg::ACT_WRITE
						&& seq_resp[3:0] != sdspi_pkg::DRESP_MASKOK)
					r = card_done(sdspi_pkg::ST_DATA_REJ);
				else
					r = card_done(sdspi_pkg::ST_OK);
			end
			default: begin
				seq_phase = PH_IDLE;
				r = bus_byte(sdspi_pkg::BYTE_IDLE, 1'b0, 1'b0);
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] card_reply();
		logic [7:0]  b;
		int unsigned r;
		b = 8'($urandom);
		r = $urandom_range(99);
		case (seq_phase)
			PH_RESP0: if (r < 70) b = sdspi_pkg::R1_IDLE;
				else if (r < 80) b = sdspi_pkg::R1_READY;
			PH_RESP1: if (r < 45) b = sdspi_pkg::R1_IDLE;
				else if (r < 85) b = sdspi_pkg::R1_READY;
			PH_RESPRW: if (r < 80) b = sdspi_pkg::R1_READY;
				else if (r < 85) b = sdspi_pkg::R1_IDLE;
			PH_TOKEN: if (r < 40) b = sdspi_pkg::TOKEN_START;
			PH_WRESP: if (r < 70) b[3:0] = sdspi_pkg::DRESP_MASKOK;
			PH_BUSY: if (r < 60) b = sdspi_pkg::BYTE_ZERO;
			default: ;
		endcase
		if (card_mute && (seq_phase == PH_RESP0 || seq_phase == PH_RESP1 ||
				seq_phase == PH_RESPRW))
			b[7] = 1'b1;
		return b;
	endfunction

	function automatic logic [31:0] pick_address();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return 32'h0000_0000;
		if (r < 20)
			return 32'hffff_ffff;
		return $urandom;
	endfunction

	function automatic string show(input sdspi_pkg::result_t r);
		return $sformatf("send=%02h sel=%0d req=%0d dv=%0d data=%02h take=%0d done=%0d st=%0d",
			r.send_byte, r.select_active, r.exchange_request, r.data_valid, r.data_byte,
			r.take_write_byte, r.done_res, r.status);
	endfunction

	task automatic send_item(input sdspi_pkg::action_t act, input logic [31:0] addr,
			input logic [7:0] reply, input logic [7:0] wdata);
		bit ignored;
		while (chance(send_idle_pct)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		block_address <= addr;
		card_byte <= reply;
		write_byte <= wdata;
		do @(posedge clk); while (in_stall);
		ignored = (act == sdspi_pkg::ACT_BYTE) && (seq_phase == PH_IDLE);
		pending_results.push_back(next_exchange(act, addr, reply, wdata));
		if (!ignored)
			items_done++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input logic [9:0] len);
		wait_drained();
		cfg_valid <= 1'b1;
		transfer_length <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seq_len = len;
	endtask

	task automatic run_op(input sdspi_pkg::action_t act, input int unsigned cut,
			input int unsigned mute_pct);
		int unsigned n;
		card_mute = chance(mute_pct);
		send_item(act, pick_address(), 8'($urandom), 8'($urandom));
		n = 0;
		while (seq_phase != PH_IDLE && (cut == 0 || n < cut)) begin
			send_item(sdspi_pkg::ACT_BYTE, $urandom, card_reply(), 8'($urandom));
			n++;
		end
	endtask

	task automatic scatter_items();
		repeat ($urandom_range(1, 6))
			send_item(chance(70) ? sdspi_pkg::ACT_BYTE
				: sdspi_pkg::action_t'($urandom_range(1, 3)),
				pick_address(), 8'($urandom), 8'($urandom));
	endtask

	task automatic run_random(input int unsigned goal);
		int unsigned pick;
		int unsigned cut;
		while (items_done < goal) begin
			pick = $urandom_range(99);
			cut = $urandom_range(1, 60);
			if (pick < 10)
				scatter_items();
			else if (pick < 35)
				run_op(sdspi_pkg::ACT_INIT, cut, 10);
			else if (pick < 68)
				run_op(sdspi_pkg::ACT_READ, cut, 10);
			else
				run_op(sdspi_pkg::ACT_WRITE, cut, 10);
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_pct = 0;
		send_item(sdspi_pkg::ACT_BYTE, 32'h0000_0000, 8'h00, 8'h00);
		send_item(sdspi_pkg::ACT_BYTE, 32'hffff_ffff, 8'hff, 8'hff);
		send_item(sdspi_pkg::ACT_WRITE, 32'hffff_ffff, 8'h00, 8'h00);
		repeat (2) send_item(sdspi_pkg::ACT_BYTE, 32'h0, 8'hff, 8'h00);
		send_item(sdspi_pkg::ACT_READ, 32'h0000_0000, 8'hff, 8'hff);
		repeat (6) send_item(sdspi_pkg::ACT_BYTE, 32'h0, 8'hff, 8'h00);
		send_item(sdspi_pkg::ACT_BYTE, 32'h0, sdspi_pkg::R1_READY, 8'h00);
		send_item(sdspi_pkg::ACT_BYTE, 32'h0, sdspi_pkg::TOKEN_START, 8'h00);
		send_item(sdspi_pkg::ACT_BYTE, 32'h0, 8'ha5, 8'h00);
		send_item(sdspi_pkg::ACT_INIT, 32'h0, 8'h00, 8'h00);
		repeat (2) send_item(sdspi_pkg::ACT_BYTE, 32'h0, 8'hff, 8'h00);
		send_item(sdspi_pkg::ACT_READ, 32'h1234_5678, 8'h00, 8'h00);
		repeat (6) send_item(sdspi_pkg::ACT_BYTE, 32'h0, 8'hff, 8'h00);
		send_item(sdspi_pkg::ACT_BYTE, 32'h0, sdspi_pkg::R1_IDLE, 8'h00);
	endtask

	task automatic test_short_write();
		set_length(10'd1);
		send_idle_pct = 0;
		recv_pct = 0;
		run_op(sdspi_pkg::ACT_WRITE, 0, 0);
		run_random(items_done + 90);
	endtask

	task automatic test_full_block_sender_gaps();
		set_length(10'd512);
		send_idle_pct = 59;
		recv_pct = 0;
		run_random(items_done + 90);
	endtask

	task automatic test_zero_length_receiver_stalls();
		set_length(10'd0);
		send_idle_pct = 0;
		recv_pct = 59;
		run_random(items_done + 90);
	endtask

	task automatic test_mid_length_both_idle();
		set_length(10'd37);
		send_idle_pct = 21;
		recv_pct = 21;
		run_random(items_done + 90);
	endtask

	task automatic test_backpressure();
		set_length(10'd1023);
		send_idle_pct = 0;
		recv_pct = 0;
		hold_ticket++;
		run_op(sdspi_pkg::ACT_READ, 0, 0);
		wait_drained();
		run_op(sdspi_pkg::ACT_INIT, 0, 0);
	endtask

	initial begin : result_monitor
		sdspi_pkg::result_t got;
		sdspi_pkg::result_t want;
		int unsigned        hold_seen;
		int unsigned        hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.send_byte = send_byte;
				got.select_active = select_active;
				got.exchange_request = exchange_request;
				got.data_valid = data_valid;
				got.data_byte = data_byte;
				got.take_write_byte = take_write_byte;
				got.done_res = done_res;
				got.status = status;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t unexpected result: %s", $realtime, show(got));
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t mismatch expected: %s", $realtime, show(want));
							$display("%0t mismatch actual:   %s", $realtime, show(got));
						end
					end
				end
			end
			if (hold_ticket != hold_seen) begin
				hold_seen = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= chance(recv_pct);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t watchdog: no item moved for %0d cycles", $realtime, WATCHDOG_CYCLES);
		$display("** sd_spi_block_sequencer_core: FAILED **");
		$finish;
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_short_write();
		test_full_block_sender_gaps();
		test_zero_length_receiver_stalls();
		test_mid_length_both_idle();
		test_backpressure();
		wait_drained();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("** sd_spi_block_sequencer_core: PASSED **");
		else
			$display("** sd_spi_block_sequencer_core: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/sdspi_pkg.sv
hw/rtl/sd_spi_block_sequencer_core.sv
hw/rtl/sdspi_checker.sv
dv/sd_spi_block_sequencer_core_tb.sv
